FILE: rtl/bdd_pkg.sv
// ----------------------------------------------------------------------------
// bdd_pkg
// Shared types and constants for the box delta decoder.
// ----------------------------------------------------------------------------
package bdd_pkg;

  localparam int ScaleW    = 16;
  localparam int NUM_TERMS = 12;          // Taylor terms of exp
  localparam int RECIP_SH  = 35;          // reciprocal scale for divide by k
  localparam int SUM_W     = 34;          // Taylor sum, Q.32, below 2.0
  localparam int EXP_W     = 37;          // exp result, Q.24
  localparam int EXP_LAT   = 3 + 3 * NUM_TERMS;

  localparam logic [ScaleW-1:0] INV_SCALE_RST = 16'd16384;
  localparam logic [33:0]       LOG2E_Q32     = 34'd6196328019;
  localparam logic [31:0]       LN2_Q32       = 32'd2977044472;

  localparam logic signed [23:0] BOX_MAX = 24'sd8388607;
  localparam logic signed [23:0] BOX_MIN = -24'sd8388608;

  typedef struct packed {
    logic        [15:0] roi_x1;
    logic        [15:0] roi_y1;
    logic        [15:0] roi_x2;
    logic        [15:0] roi_y2;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] delta_w;
    logic signed [15:0] delta_h;
  } bdd_in_t;

  typedef struct packed {
    logic signed [23:0] box_x1;
    logic signed [23:0] box_y1;
    logic signed [23:0] box_x2;
    logic signed [23:0] box_y2;
    logic               clipped;
  } bdd_out_t;

  typedef struct packed {
    logic signed [19:0] ctr;    // x1+x2, Q.4
    logic signed [34:0] shift;  // delta*w, Q.16
    logic signed [18:0] w;      // Q.4
  } bdd_axis_t;

endpackage

FILE: rtl/box_delta_decode_core.sv
// ----------------------------------------------------------------------------
// box_delta_decode_core
// Decodes a region proposal plus regression deltas into a predicted box.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request:
//   four proposal corners (Q12.4) and four deltas (Q3.12). Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns the box in Q20.4 with a
//   clipped flag when any corner saturated.
//   cfg_we_i writes inv_scale (Q2.14) from cfg_wdata_i; write only when idle.
//   One request per cycle is taken while out_stall_i does not hold a valid
//   result; the depth comes from the exp unit, a 12-term Taylor
//   chain of three stages per term (multiply, reciprocal divide, correct).
//   Reset empties the pipeline and sets inv_scale to 1.0.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall_o is raised in the same cycle; nothing is dropped or repeated.
//   Bubbles propagate while the output is empty or taken.
// ----------------------------------------------------------------------------
module box_delta_decode_core import bdd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bdd_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bdd_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [ScaleW-1:0] cfg_wdata_i
);

  localparam int NSTG = EXP_LAT + 4;
  localparam int DLY  = EXP_LAT - 1;

  logic              en;
  logic [NSTG-1:0]   v_q;
  logic [ScaleW-1:0] inv_q;
  bdd_in_t           in_q;

  logic        [17:0] a_q  [2];
  logic        [17:0] b_q  [2];
  logic signed [15:0] dc_q [2];
  logic        [15:0] lo_c [2];
  logic        [15:0] hi_c [2];
  logic signed [15:0] dc_c [2];
  bdd_axis_t          ax_d [2];
  bdd_axis_t          ax_q [DLY][2];

  logic [EXP_W-1:0]   exp_w [2];
  logic signed [58:0] half_q [2];
  logic signed [58:0] c_q    [2];
  logic signed [58:0] lo_q   [2];
  logic signed [58:0] hi_q   [2];

  logic [24:0] rx1, ry1, rx2, ry2;
  bdd_out_t    out_d, out_q;

  function automatic logic [17:0] rescale(input logic [15:0] c, input logic [15:0] s);
    logic [32:0] p;
    p = 33'(c) * 33'(s) + 33'd8192;
    return p[31:14];
  endfunction

  // Q.29 to Q.4, round half up, saturate; bit 24 flags saturation
  function automatic logic [24:0] to_out(input logic signed [58:0] v);
    logic signed [58:0] r;
    logic signed [33:0] q;
    r = v + (59'sd1 <<< 24);
    q = r[58:25];
    if (q > 34'(BOX_MAX))      return {1'b1, BOX_MAX};
    else if (q < 34'(BOX_MIN)) return {1'b1, BOX_MIN};
    else                       return {1'b0, q[23:0]};
  endfunction

  assign en         = !v_q[NSTG-1] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= INV_SCALE_RST;
    end else if (cfg_we_i) begin
      inv_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) in_q <= in_data_i;
  end

  assign lo_c[0] = in_q.roi_x1;
  assign hi_c[0] = in_q.roi_x2;
  assign dc_c[0] = in_q.delta_x;
  assign lo_c[1] = in_q.roi_y1;
  assign hi_c[1] = in_q.roi_y2;
  assign dc_c[1] = in_q.delta_y;

  bdd_exp u_exp_w (.clk_i(clk_i), .en_i(en), .d_i(in_q.delta_w), .exp_o(exp_w[0]));
  bdd_exp u_exp_h (.clk_i(clk_i), .en_i(en), .d_i(in_q.delta_h), .exp_o(exp_w[1]));

  for (genvar x = 0; x < 2; x++) begin : g_axis
    always_ff @(posedge clk_i) begin
      if (en) begin
        a_q[x]  <= rescale(lo_c[x], inv_q);
        b_q[x]  <= rescale(hi_c[x], inv_q);
        dc_q[x] <= dc_c[x];
      end
    end

    always_comb begin
      ax_d[x].w     = $signed({1'b0, b_q[x]}) - $signed({1'b0, a_q[x]});
      ax_d[x].ctr   = $signed(20'(a_q[x]) + 20'(b_q[x]));
      ax_d[x].shift = 35'(dc_q[x]) * 35'(ax_d[x].w);
    end

    always_ff @(posedge clk_i) begin
      if (en) ax_q[0][x] <= ax_d[x];
    end

    for (genvar i = 1; i < DLY; i++) begin : g_dly
      always_ff @(posedge clk_i) begin
        if (en) ax_q[i][x] <= ax_q[i-1][x];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        half_q[x] <= 59'($signed({1'b0, exp_w[x]})) * 59'(ax_q[DLY-1][x].w);
        c_q[x]    <= (59'(ax_q[DLY-1][x].ctr) <<< 24)
                   + (59'(ax_q[DLY-1][x].shift) <<< 13);
        lo_q[x]   <= c_q[x] - half_q[x];
        hi_q[x]   <= c_q[x] + half_q[x];
      end
    end
  end

  always_comb begin
    rx1 = to_out(lo_q[0]);
    ry1 = to_out(lo_q[1]);
    rx2 = to_out(hi_q[0]);
    ry2 = to_out(hi_q[1]);
    out_d.box_x1  = rx1[23:0];
    out_d.box_y1  = ry1[23:0];
    out_d.box_x2  = rx2[23:0];
    out_d.box_y2  = ry2[23:0];
    out_d.clipped = rx1[24] | ry1[24] | rx2[24] | ry2[24];
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = v_q[NSTG-1];
  assign out_data_o  = out_q;

endmodule

FILE: rtl/bdd_term.sv
// ----------------------------------------------------------------------------
// bdd_term
// One Taylor term: term = ((term * z) >> 32) / K, sum += term. Three stages.
// ----------------------------------------------------------------------------
module bdd_term import bdd_pkg::*; #(
  parameter int unsigned K = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [31:0]      z_i,
  input  logic [32:0]      term_i,
  input  logic [SUM_W-1:0] sum_i,
  output logic [31:0]      z_o,
  output logic [31:0]      term_o,
  output logic [SUM_W-1:0] sum_o
);

  localparam logic [RECIP_SH:0] RECIP = (RECIP_SH+1)'((64'd1 << RECIP_SH) / K);

  logic [64:0]      prod_a;
  logic [31:0]      x_a_q, z_a_q;
  logic [SUM_W-1:0] sum_a_q;

  logic [67:0]      prod_b;
  logic [31:0]      q0_d;
  logic [31:0]      q0_b_q, x_b_q, z_b_q;
  logic [SUM_W-1:0] sum_b_q;

  logic [35:0]      qk, rem;
  logic [31:0]      q_d;
  logic [31:0]      term_c_q, z_c_q;
  logic [SUM_W-1:0] sum_c_q;

  assign prod_a = 65'(term_i) * 65'(z_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_a_q   <= prod_a[63:32];
      z_a_q   <= z_i;
      sum_a_q <= sum_i;
    end
  end

  // estimate may fall one short; fixed in the next stage
  assign prod_b = 68'(x_a_q) * 68'(RECIP);
  assign q0_d   = (K == 1) ? x_a_q : prod_b[RECIP_SH+31:RECIP_SH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_b_q  <= q0_d;
      x_b_q   <= x_a_q;
      z_b_q   <= z_a_q;
      sum_b_q <= sum_a_q;
    end
  end

  assign qk  = 36'(q0_b_q) * 36'(K);
  assign rem = 36'(x_b_q) - qk;
  assign q_d = (rem >= 36'(K)) ? q0_b_q + 32'd1 : q0_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_c_q <= q_d;
      z_c_q    <= z_b_q;
      sum_c_q  <= sum_b_q + SUM_W'(q_d);
    end
  end

  assign z_o    = z_c_q;
  assign term_o = term_c_q;
  assign sum_o  = sum_c_q;

endmodule

FILE: rtl/bdd_exp.sv
// ----------------------------------------------------------------------------
// bdd_exp
// exp(d / 4096) in Q.24 via 2^n * exp(f*ln2), Taylor series in Q.32.
// ----------------------------------------------------------------------------
module bdd_exp import bdd_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] d_i,
  output logic [EXP_W-1:0]   exp_o
);

  localparam int NDLY = 3 * NUM_TERMS + 1;

  logic signed [49:0] tmul;
  logic        [48:0] t_q;
  logic        [48:0] ub;
  logic        [63:0] zprod;
  logic        [31:0] z0_q;

  logic [31:0]      z_w    [NUM_TERMS+1];
  logic [32:0]      term_w [NUM_TERMS];
  logic [31:0]      tout_w [NUM_TERMS];
  logic [SUM_W-1:0] sum_w  [NUM_TERMS+1];
  logic [4:0]       n_q    [NDLY];

  logic [4:0]       nraw;
  logic [4:0]       rsh;
  logic [EXP_W-1:0] exp_d, exp_q;

  assign tmul = 50'(d_i) * $signed({16'd0, LOG2E_Q32});

  always_ff @(posedge clk_i) begin
    if (en_i) t_q <= tmul[48:0];
  end

  // bias keeps the split positive: integer part is ub[48:44] - 16
  assign ub    = t_q + (49'd1 << 48);
  assign zprod = 64'(ub[43:12]) * 64'(LN2_Q32);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q    <= zprod[63:32];
      n_q[0]  <= ub[48:44];
    end
  end

  assign z_w[0]    = z0_q;
  assign term_w[0] = 33'd1 << 32;
  assign sum_w[0]  = SUM_W'(64'd1 << 32);

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    bdd_term #(.K(k + 1)) u_term (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .z_i    (z_w[k]),
      .term_i (term_w[k]),
      .sum_i  (sum_w[k]),
      .z_o    (z_w[k+1]),
      .term_o (tout_w[k]),
      .sum_o  (sum_w[k+1])
    );
    if (k + 1 < NUM_TERMS) begin : g_link
      assign term_w[k+1] = {1'b0, tout_w[k]};
    end
  end

  for (genvar i = 1; i < NDLY; i++) begin : g_ndly
    always_ff @(posedge clk_i) begin
      if (en_i) n_q[i] <= n_q[i-1];
    end
  end

  // scale by 2^(n-8): left exact, right rounds half up
  assign nraw = n_q[NDLY-1];
  assign rsh  = 5'd24 - nraw;

  always_comb begin
    if (nraw >= 5'd24) begin
      exp_d = EXP_W'(sum_w[NUM_TERMS]) << (nraw - 5'd24);
    end else begin
      exp_d = (EXP_W'(sum_w[NUM_TERMS]) + (EXP_W'(1) << (rsh - 5'd1))) >> rsh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) exp_q <= exp_d;
  end

  assign exp_o = exp_q;

endmodule

FILE: rtl/bdd_checker.sv
// ----------------------------------------------------------------------------
// bdd_checker
// Port-level checks for box_delta_decode_core, attached by bind.
// ----------------------------------------------------------------------------
module bdd_checker import bdd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input bdd_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // input side only stalls when a finished result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      out_data_o.box_x1 == BOX_MAX || out_data_o.box_x1 == BOX_MIN ||
      out_data_o.box_y1 == BOX_MAX || out_data_o.box_y1 == BOX_MIN ||
      out_data_o.box_x2 == BOX_MAX || out_data_o.box_x2 == BOX_MIN ||
      out_data_o.box_y2 == BOX_MAX || out_data_o.box_y2 == BOX_MIN)
    else $error("clipped set with no coordinate at a rail");

endmodule

bind box_delta_decode_core bdd_checker u_bdd_checker (.*);
